// ===== sv/lcc_pkg.sv =====
// Shared types and constants for the LBA / CHS address converter.
// Depends on nothing; every other file of the block imports it.
package lcc_pkg;

  localparam int AddrW = 32;
  localparam int CylW  = 8;
  localparam int HeadW = 8;
  localparam int SecW  = 6;
  localparam int BpsW  = 16;
  localparam int SptW  = 6;
  localparam int HcW   = 8;
  localparam int SpchW = SptW + HcW;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;
  localparam int InDataW  = 56;
  localparam int OutDataW = 56;

  localparam logic [BpsW-1:0] BpsReset = BpsW'(512);
  localparam logic [SptW-1:0] SptReset = SptW'(63);
  localparam logic [HcW-1:0]  HcReset  = HcW'(255);

  typedef enum logic [CfgIdxW-1:0] {
    REG_BPS = 2'd0,
    REG_SPT = 2'd1,
    REG_HC  = 2'd2
  } cfg_reg_t;

  localparam logic OP_TO_CHS  = 1'b0;
  localparam logic OP_TO_ADDR = 1'b1;

  // Side data riding along the first two divider chains.
  typedef struct packed {
    logic             op;
    logic             oor;
    logic [AddrW-1:0] addr;
  } rev_side_t;

  // Side data riding along the last divider chain.
  typedef struct packed {
    rev_side_t       rv;
    logic [CylW-1:0] cyl;
    logic            ovf;
  } fwd_side_t;

endpackage

// ===== sv/lcc_div_cell.sv =====
// One restoring-division cell: produces one quotient bit per item and hands
// the partial remainder on to the next cell. Uses lcc_pkg.
module lcc_div_cell
  import lcc_pkg::*;
#(
  parameter int DW = 32,
  parameter int VW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [VW-1:0] in_rem,
  input  logic [DW-1:0] in_dv,
  input  logic [SW-1:0] in_side,
  input  logic [VW-1:0] divisor,
  output logic          out_valid,
  output logic [VW-1:0] out_rem,
  output logic [DW-1:0] out_dv,
  output logic [SW-1:0] out_side
);

  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;
  logic [VW-1:0] rem_nxt;
  logic [DW-1:0] dv_nxt;
  logic          valid_r;
  logic [VW-1:0] rem_r;
  logic [DW-1:0] dv_r;
  logic [SW-1:0] side_r;

  always_comb begin
    trial   = {in_rem, in_dv[DW-1]};
    diff    = trial - {1'b0, divisor};
    ge      = trial >= {1'b0, divisor};
    rem_nxt = ge ? diff[VW-1:0] : trial[VW-1:0];
    dv_nxt  = {in_dv[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      dv_r   <= dv_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_dv    = dv_r;
  assign out_side  = side_r;

endmodule

// ===== sv/lcc_div_chain.sv =====
// A row of DW division cells that divides a DW-bit dividend by a VW-bit
// divisor, one quotient bit per cell. Uses lcc_pkg and lcc_div_cell.
module lcc_div_chain
  import lcc_pkg::*;
#(
  parameter int DW = 32,
  parameter int VW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] dividend,
  input  logic [SW-1:0] in_side,
  input  logic [VW-1:0] divisor,
  output logic          out_valid,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder,
  output logic [SW-1:0] out_side
);

  logic          valid_w [0:DW];
  logic [VW-1:0] rem_w   [0:DW];
  logic [DW-1:0] dv_w    [0:DW];
  logic [SW-1:0] side_w  [0:DW];

  assign valid_w[0] = in_valid;
  assign rem_w[0]   = '0;
  assign dv_w[0]    = dividend;
  assign side_w[0]  = in_side;

  for (genvar i = 0; i < DW; i++) begin : g_cell
    lcc_div_cell #(.DW(DW), .VW(VW), .SW(SW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (valid_w[i]),
      .in_rem   (rem_w[i]),
      .in_dv    (dv_w[i]),
      .in_side  (side_w[i]),
      .divisor  (divisor),
      .out_valid(valid_w[i+1]),
      .out_rem  (rem_w[i+1]),
      .out_dv   (dv_w[i+1]),
      .out_side (side_w[i+1])
    );
  end

  assign out_valid = valid_w[DW];
  assign quotient  = dv_w[DW];
  assign remainder = rem_w[DW];
  assign out_side  = side_w[DW];

endmodule

// ===== sv/lba_chs_address_convert_core.sv =====
// Top level of the LBA / CHS address converter: geometry registers, the
// reverse multiply stages, three division chains and the output register.
// Uses lcc_pkg and lcc_div_chain.
//
//   channel | direction | contents
//   in_     | slave     | tuser: operation; tdata: byte_address, cylinder, head, sector
//   out_    | master    | tdata: cylinder, head, sector, address, out_of_range
//   cfg_    | write     | cfg_we, cfg_index, cfg_data
//
// One item is accepted per cycle while the output side keeps up; each item
// passes through one input register, three multiply stages, 32 + 32 + 14
// division cells and the output register.
// Reset (synchronous, active low) empties the pipeline and restores the
// geometry to 512 bytes, 63 sectors and 255 heads.
// The whole pipeline advances together; it holds only while a result waits
// in the output register and out_tready is low.
module lba_chs_address_convert_core
  import lcc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // [31:0] byte_address, [39:32] cylinder_in, [47:40] head_in, [53:48] sector_in
  input  logic [InDataW-1:0]  in_tdata,
  // [0] operation
  input  logic                in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // [7:0] cylinder_out, [15:8] head_out, [21:16] sector_out,
  // [53:22] address_out, [54] out_of_range
  output logic [OutDataW-1:0] out_tdata,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // Geometry registers.
  logic [BpsW-1:0] bps_r;
  logic [SptW-1:0] spt_r;
  logic [HcW-1:0]  hc_r;
  logic [BpsW-1:0] bps;
  logic [SptW-1:0] spt;
  logic [HcW-1:0]  hc;
  logic [SpchW-1:0] spch;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bps_r <= BpsReset;
      spt_r <= SptReset;
      hc_r  <= HcReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BPS: bps_r <= cfg_data[BpsW-1:0];
        REG_SPT: spt_r <= cfg_data[SptW-1:0];
        REG_HC:  hc_r  <= cfg_data[HcW-1:0];
        default: ;
      endcase
    end
  end

  // A zero register counts as one in all arithmetic.
  assign bps  = (bps_r == '0) ? BpsW'(1) : bps_r;
  assign spt  = (spt_r == '0) ? SptW'(1) : spt_r;
  assign hc   = (hc_r == '0) ? HcW'(1) : hc_r;
  assign spch = SpchW'(spt) * SpchW'(hc);

  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Stage 0: captured item.
  logic             s0_valid_r, s0_op_r;
  logic [AddrW-1:0] s0_a_r;
  logic [CylW-1:0]  s0_c_r;
  logic [HeadW-1:0] s0_h_r;
  logic [SecW-1:0]  s0_s_r;
  // Stage 1: cylinder * heads + head.
  logic             s1_valid_r, s1_op_r;
  logic [AddrW-1:0] s1_a_r;
  logic [15:0]      s1_ch_r;
  logic [SecW-1:0]  s1_s_r;
  logic [15:0]      s1_ch_nxt;
  // Stage 2: linear sector number.
  logic             s2_valid_r, s2_op_r, s2_oor_r;
  logic [AddrW-1:0] s2_a_r;
  logic [AddrW-1:0] s2_sn_r;
  logic [AddrW-1:0] s2_sn_nxt;
  // Stage 3: scaled byte address.
  logic             s3_valid_r, s3_op_r, s3_oor_r;
  logic [AddrW-1:0] s3_a_r;
  logic [AddrW-1:0] s3_addr_r;
  logic [AddrW-1:0] s3_addr_nxt;

  always_comb begin
    s1_ch_nxt   = 16'(s0_c_r) * 16'(hc) + 16'(s0_h_r);
    s2_sn_nxt   = AddrW'(22'(s1_ch_r) * 22'(spt)) + AddrW'(s1_s_r) - AddrW'(1);
    s3_addr_nxt = s2_sn_r * AddrW'(bps);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_tvalid;
      s1_valid_r <= s0_valid_r;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_op_r   <= in_tuser;
      s0_a_r    <= in_tdata[31:0];
      s0_c_r    <= in_tdata[39:32];
      s0_h_r    <= in_tdata[47:40];
      s0_s_r    <= in_tdata[53:48];
      s1_op_r   <= s0_op_r;
      s1_a_r    <= s0_a_r;
      s1_ch_r   <= s1_ch_nxt;
      s1_s_r    <= s0_s_r;
      s2_op_r   <= s1_op_r;
      s2_a_r    <= s1_a_r;
      s2_sn_r   <= s2_sn_nxt;
      s2_oor_r  <= (s1_s_r == '0);
      s3_op_r   <= s2_op_r;
      s3_a_r    <= s2_a_r;
      s3_oor_r  <= s2_oor_r;
      s3_addr_r <= s3_addr_nxt;
    end
  end

  // Byte address to sector number.
  rev_side_t        d1_side_in, d1_side, d2_side;
  logic             d1_valid, d2_valid, d3_valid;
  logic [AddrW-1:0] d1_q, d2_q;
  logic [BpsW-1:0]  d1_rem;
  logic [SpchW-1:0] d2_rem;
  fwd_side_t        d3_side_in, d3_side;
  logic [SpchW-1:0] d3_q;
  logic [SptW-1:0]  d3_rem;

  assign d1_side_in = '{op: s3_op_r, oor: s3_oor_r, addr: s3_addr_r};

  lcc_div_chain #(.DW(AddrW), .VW(BpsW), .SW($bits(rev_side_t))) u_div_sector (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s3_valid_r), .dividend(s3_a_r), .in_side(d1_side_in), .divisor(bps),
    .out_valid(d1_valid), .quotient(d1_q), .remainder(d1_rem), .out_side(d1_side)
  );

  // Sector number to cylinder; the remainder is the sector within the cylinder.
  lcc_div_chain #(.DW(AddrW), .VW(SpchW), .SW($bits(rev_side_t))) u_div_cyl (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(d1_valid), .dividend(d1_q), .in_side(d1_side), .divisor(spch),
    .out_valid(d2_valid), .quotient(d2_q), .remainder(d2_rem), .out_side(d2_side)
  );

  assign d3_side_in = '{rv: d2_side, cyl: d2_q[CylW-1:0], ovf: |d2_q[AddrW-1:CylW]};

  // Sector within the cylinder to head; the remainder gives the sector.
  lcc_div_chain #(.DW(SpchW), .VW(SptW), .SW($bits(fwd_side_t))) u_div_head (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(d2_valid), .dividend(d2_rem), .in_side(d3_side_in), .divisor(spt),
    .out_valid(d3_valid), .quotient(d3_q), .remainder(d3_rem), .out_side(d3_side)
  );

  // The remainder of the first division is not needed.
  logic unused_rem;
  assign unused_rem = ^d1_rem;

  // Output register; the unused fields of each mode read as zero.
  logic [OutDataW-1:0] out_data_r;
  logic [OutDataW-1:0] out_data_nxt;

  always_comb begin
    out_data_nxt = '0;
    if (d3_side.rv.op == OP_TO_ADDR) begin
      out_data_nxt[53:22] = d3_side.rv.addr;
      out_data_nxt[54]    = d3_side.rv.oor;
    end else begin
      out_data_nxt[7:0]   = d3_side.cyl;
      out_data_nxt[15:8]  = d3_q[HeadW-1:0];
      out_data_nxt[21:16] = d3_rem + SecW'(1);
      out_data_nxt[54]    = d3_side.ovf;
    end
    out_data_nxt[55] = unused_rem & 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== sv/lcc_checker.sv =====
// Port-level checks for the LBA / CHS address converter, bound to the top.
// Uses lcc_pkg.
module lcc_port_props
  import lcc_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata
);

  // A waiting result holds its data.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The input side is open whenever the output register is free.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // A forward result always carries a one-based sector and no address.
  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[21:16] != '0 |-> out_tdata[53:22] == '0)
    else $error("forward result carries an address");

  // A reverse result carries no cylinder or head.
  a_rev: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[21:16] == '0 |-> out_tdata[15:0] == '0)
    else $error("reverse result carries a position");

endmodule

bind lba_chs_address_convert_core lcc_port_props u_lcc_port_props (.*);
